FILE: rtl/pcbh_pkg.sv
// Shared constants, codes and types for the particle cell binning histogram.
package pcbh_pkg;

  localparam int CELLS_X = 16;
  localparam int CELLS_Y = 16;
  localparam int CELLS_Z = 16;

  localparam int POS_W   = 32;
  localparam int INV_W   = 32;
  localparam int IDX_W   = 12;
  localparam int CNT_W   = 17;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 32;

  localparam int HIST_DEPTH  = 2 ** IDX_W;
  localparam int CELLS_TOTAL = CELLS_X * CELLS_Y * CELLS_Z;

  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'((CELLS_TOTAL - 1) % HIST_DEPTH);
  localparam logic [IDX_W-1:0] STRIDE_Y  = IDX_W'(CELLS_Z % HIST_DEPTH);
  localparam logic [IDX_W-1:0] STRIDE_X  = IDX_W'((CELLS_Y * CELLS_Z) % HIST_DEPTH);

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_START    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PARTICLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z    = 3'd5;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_START,
    OP_PART,
    OP_READ
  } op_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [IDX_W-1:0] addr;
    logic             in_range;
  } hist_req_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] cell_index;
    logic             in_range;
    logic [CNT_W-1:0] count;
  } hist_res_t;

  typedef struct packed {
    logic busy;
    logic clr_done;
  } hist_stat_t;

endpackage

FILE: rtl/pcbh_if.sv
// Valid/ready channel interfaces for particle requests and histogram results.
interface pcbh_in_if;
  logic                                valid;
  logic                                ready;
  logic        [pcbh_pkg::MODE_W-1:0]  mode;
  logic signed [pcbh_pkg::POS_W-1:0]   pos_x;
  logic signed [pcbh_pkg::POS_W-1:0]   pos_y;
  logic signed [pcbh_pkg::POS_W-1:0]   pos_z;
  logic                                dead;
  logic        [pcbh_pkg::IDX_W-1:0]   read_cell;

  modport source (output valid, mode, pos_x, pos_y, pos_z, dead, read_cell, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, pos_z, dead, read_cell, output ready);
endinterface

interface pcbh_out_if;
  logic                         valid;
  logic                         ready;
  logic [pcbh_pkg::IDX_W-1:0]   cell_index;
  logic                         in_range;
  logic [pcbh_pkg::CNT_W-1:0]   count;

  modport source (output valid, cell_index, in_range, count, input ready);
  modport sink   (input valid, cell_index, in_range, count, output ready);
endinterface

FILE: rtl/pcbh_axis.sv
// One axis of the cell coordinate: offset from origin, then scale by inverse cell size.
module pcbh_axis (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [pcbh_pkg::POS_W-1:0]  pos,
  input  logic signed [pcbh_pkg::POS_W-1:0]  org,
  input  logic        [pcbh_pkg::INV_W-1:0]  inv,
  output logic        [pcbh_pkg::POS_W-1:0]  coord,
  output logic                               neg_nz
);

  logic signed [pcbh_pkg::POS_W:0]             diff;
  logic        [pcbh_pkg::POS_W-1:0]           mag_nxt;
  logic        [pcbh_pkg::POS_W-1:0]           mag_r;
  logic                                        neg_r;
  logic        [pcbh_pkg::POS_W+pcbh_pkg::INV_W-1:0] prod;
  logic        [pcbh_pkg::POS_W-1:0]           coord_r;
  logic                                        neg_nz_r;

  assign diff    = {pos[pcbh_pkg::POS_W-1], pos} - {org[pcbh_pkg::POS_W-1], org};
  assign mag_nxt = diff[pcbh_pkg::POS_W] ? pcbh_pkg::POS_W'(-diff)
                                         : pcbh_pkg::POS_W'(diff);
  assign prod    = (pcbh_pkg::POS_W+pcbh_pkg::INV_W)'(mag_r)
                 * (pcbh_pkg::POS_W+pcbh_pkg::INV_W)'(inv);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r    <= diff[pcbh_pkg::POS_W];
      mag_r    <= mag_nxt;
      coord_r  <= prod[pcbh_pkg::POS_W+pcbh_pkg::INV_W-1:pcbh_pkg::INV_W];
      // product is zero exactly when one factor is zero
      neg_nz_r <= neg_r && (mag_r != '0) && (inv != '0);
    end
  end

  assign coord  = coord_r;
  assign neg_nz = neg_nz_r;

endmodule

FILE: rtl/pcbh_hist_ram.sv
// Histogram count memory: one write port, one registered read port.
module pcbh_hist_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [pcbh_pkg::IDX_W-1:0]   waddr,
  input  logic [pcbh_pkg::CNT_W-1:0]   wdata,
  input  logic                         re,
  input  logic [pcbh_pkg::IDX_W-1:0]   raddr,
  output logic [pcbh_pkg::CNT_W-1:0]   rdata
);

  logic [pcbh_pkg::CNT_W-1:0] mem [pcbh_pkg::HIST_DEPTH];
  logic [pcbh_pkg::CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pcbh_hist.sv
// Histogram read-modify-write stage with write forwarding and the clearing sweep.
module pcbh_hist (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  pcbh_pkg::hist_req_t    req,
  output pcbh_pkg::hist_res_t    res,
  output pcbh_pkg::hist_stat_t   stat
);

  pcbh_pkg::state_t               state_r, state_nxt;
  logic [pcbh_pkg::IDX_W-1:0]     clr_addr_r, clr_addr_nxt;
  pcbh_pkg::hist_req_t            rmw_r;
  logic                           fwd_vld_r;
  logic [pcbh_pkg::IDX_W-1:0]     fwd_addr_r;
  logic [pcbh_pkg::CNT_W-1:0]     fwd_data_r;
  logic [pcbh_pkg::CNT_W-1:0]     rd_data;
  logic [pcbh_pkg::CNT_W-1:0]     cur;
  logic [pcbh_pkg::CNT_W-1:0]     inc;
  logic                           part_wr;
  logic                           clr_we;
  logic                           ram_we;
  logic [pcbh_pkg::IDX_W-1:0]     ram_waddr;
  logic [pcbh_pkg::CNT_W-1:0]     ram_wdata;

  pcbh_hist_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (req.addr),
    .rdata (rd_data)
  );

  // take the count written on the edge that latched this read
  assign cur     = (fwd_vld_r && (fwd_addr_r == rmw_r.addr)) ? fwd_data_r : rd_data;
  assign inc     = (&cur) ? cur : cur + 1'b1;
  assign part_wr = adv && rmw_r.valid && (rmw_r.op == pcbh_pkg::OP_PART);

  // next state
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = '0;
    case (state_r)
      pcbh_pkg::ST_RUN: begin
        if (adv && rmw_r.valid && (rmw_r.op == pcbh_pkg::OP_START)) begin
          state_nxt = pcbh_pkg::ST_CLEAR;
        end
      end
      pcbh_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = pcbh_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = pcbh_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    clr_we        = 1'b0;
    stat.busy     = 1'b0;
    stat.clr_done = 1'b0;
    case (state_r)
      pcbh_pkg::ST_RUN: begin
        clr_we = 1'b0;
      end
      pcbh_pkg::ST_CLEAR: begin
        clr_we        = 1'b1;
        stat.busy     = 1'b1;
        stat.clr_done = &clr_addr_r;
      end
      default: begin
        stat.busy = 1'b1;
      end
    endcase
  end

  assign ram_we    = clr_we || part_wr;
  assign ram_waddr = clr_we ? clr_addr_r : rmw_r.addr;
  assign ram_wdata = clr_we ? '0 : inc;

  always_comb begin
    res.valid      = rmw_r.valid;
    res.cell_index = '0;
    res.in_range   = 1'b0;
    res.count      = '0;
    case (rmw_r.op)
      pcbh_pkg::OP_PART: begin
        res.cell_index = rmw_r.addr;
        res.in_range   = rmw_r.in_range;
        res.count      = inc;
      end
      pcbh_pkg::OP_READ: begin
        res.cell_index = rmw_r.addr;
        res.count      = cur;
      end
      default: begin
        res.count = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pcbh_pkg::ST_CLEAR;
      clr_addr_r <= '0;
      rmw_r      <= '0;
      fwd_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (clr_we) begin
        fwd_vld_r <= 1'b0;
      end else if (adv) begin
        fwd_vld_r <= part_wr;
      end
      if (adv) begin
        rmw_r <= req;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (part_wr) begin
      fwd_addr_r <= rmw_r.addr;
      fwd_data_r <= inc;
    end
  end

`ifndef SYNTH
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcbh_pkg::ST_CLEAR) |-> !rmw_r.valid)
    else $error("item in read-modify-write stage during clearing sweep");

  a_part_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (rmw_r.valid && (rmw_r.op == pcbh_pkg::OP_PART)) |-> (res.count != '0))
    else $error("particle result carries a zero count");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pcbh_pkg::ST_CLEAR) && (&clr_addr_r)) |=> (state_r == pcbh_pkg::ST_RUN))
    else $error("clearing sweep did not end after last entry");
`endif

endmodule

FILE: rtl/particle_cell_binning_histogram.sv
// Top level of the particle cell binning histogram: config, index pipeline, result register.
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid/ready   | mode, pos_x, pos_y, pos_z, dead, read_cell
//   out_ch   | out | valid/ready   | cell_index, in_range, count
//   cfg_*    | in  | cfg_we strobe | cfg_idx, cfg_data
//
// One item per cycle sustained while the output is not stalled and no clearing sweep runs;
// after acceptance a request passes these registered steps: offset registered at acceptance,
// then product, index plus memory read, read-modify-write into the output register.
// The histogram memory has one write and one read port; writes are forwarded to a
// read of the same entry in the next item.
// After reset and after each start request a clearing sweep of all 4096 entries runs;
// in_ch.ready stays low from acceptance of the start request until the sweep ends.
// A stalled output holds the whole pipeline.
module particle_cell_binning_histogram (
  input  logic                              clk,
  input  logic                              rst_n,
  pcbh_in_if.sink                           in_ch,
  pcbh_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [pcbh_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pcbh_pkg::CFG_W-1:0]        cfg_data
);

  logic signed [pcbh_pkg::POS_W-1:0] org_x_r, org_y_r, org_z_r;
  logic        [pcbh_pkg::INV_W-1:0] inv_x_r, inv_y_r, inv_z_r;

  logic                        adv;
  logic                        accept;
  logic                        pend_r;
  pcbh_pkg::op_t               op_in;

  logic                        s1_vld_r, s2_vld_r;
  pcbh_pkg::op_t               s1_op_r, s2_op_r;
  logic                        s1_dead_r, s2_dead_r;
  logic [pcbh_pkg::IDX_W-1:0]  s1_rcell_r, s2_rcell_r;

  logic [pcbh_pkg::POS_W-1:0]  cx, cy, cz;
  logic                        nx, ny, nz;
  logic                        inr;
  logic [pcbh_pkg::IDX_W-1:0]  flat;
  logic [pcbh_pkg::IDX_W-1:0]  last_bucket_r;

  pcbh_pkg::hist_req_t         req;
  pcbh_pkg::hist_res_t         res;
  pcbh_pkg::hist_stat_t        stat;

  logic                        out_vld_r;
  logic [pcbh_pkg::IDX_W-1:0]  out_cell_r;
  logic                        out_inr_r;
  logic [pcbh_pkg::CNT_W-1:0]  out_cnt_r;

  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv && !stat.busy && !pend_r;
  assign accept       = in_ch.valid && in_ch.ready;

  always_comb begin
    case (in_ch.mode)
      pcbh_pkg::MODE_START:    op_in = pcbh_pkg::OP_START;
      pcbh_pkg::MODE_PARTICLE: op_in = pcbh_pkg::OP_PART;
      pcbh_pkg::MODE_READ:     op_in = pcbh_pkg::OP_READ;
      default:                 op_in = pcbh_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      inv_x_r <= 32'd65536;
      inv_y_r <= 32'd65536;
      inv_z_r <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_idx)
        pcbh_pkg::CFG_ORIGIN_X: org_x_r <= cfg_data;
        pcbh_pkg::CFG_ORIGIN_Y: org_y_r <= cfg_data;
        pcbh_pkg::CFG_ORIGIN_Z: org_z_r <= cfg_data;
        pcbh_pkg::CFG_INV_X:    inv_x_r <= cfg_data;
        pcbh_pkg::CFG_INV_Y:    inv_y_r <= cfg_data;
        pcbh_pkg::CFG_INV_Z:    inv_z_r <= cfg_data;
        default:                inv_z_r <= inv_z_r;
      endcase
    end
  end

  pcbh_axis u_axis_x (
    .clk (clk), .en (adv), .pos (in_ch.pos_x), .org (org_x_r), .inv (inv_x_r),
    .coord (cx), .neg_nz (nx)
  );
  pcbh_axis u_axis_y (
    .clk (clk), .en (adv), .pos (in_ch.pos_y), .org (org_y_r), .inv (inv_y_r),
    .coord (cy), .neg_nz (ny)
  );
  pcbh_axis u_axis_z (
    .clk (clk), .en (adv), .pos (in_ch.pos_z), .org (org_z_r), .inv (inv_z_r),
    .coord (cz), .neg_nz (nz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= op_in;
      s1_dead_r  <= in_ch.dead;
      s1_rcell_r <= in_ch.read_cell;
      s2_op_r    <= s1_op_r;
      s2_dead_r  <= s1_dead_r;
      s2_rcell_r <= s1_rcell_r;
    end
  end

  assign inr = !nx && !ny && !nz
            && (cx < pcbh_pkg::POS_W'(pcbh_pkg::CELLS_X))
            && (cy < pcbh_pkg::POS_W'(pcbh_pkg::CELLS_Y))
            && (cz < pcbh_pkg::POS_W'(pcbh_pkg::CELLS_Z));

  // flat index modulo histogram depth
  assign flat = cz[pcbh_pkg::IDX_W-1:0]
              + pcbh_pkg::IDX_W'(cy[pcbh_pkg::IDX_W-1:0] * pcbh_pkg::STRIDE_Y)
              + pcbh_pkg::IDX_W'(cx[pcbh_pkg::IDX_W-1:0] * pcbh_pkg::STRIDE_X);

  always_comb begin
    req.valid    = s2_vld_r;
    req.op       = s2_op_r;
    req.addr     = '0;
    req.in_range = 1'b0;
    case (s2_op_r)
      pcbh_pkg::OP_PART: begin
        if (s2_dead_r) begin
          req.addr = last_bucket_r;
        end else begin
          req.addr     = inr ? flat : pcbh_pkg::LAST_CELL;
          req.in_range = inr;
        end
      end
      pcbh_pkg::OP_READ: begin
        req.addr = s2_rcell_r;
      end
      default: begin
        req.addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_bucket_r <= '0;
    end else if (adv && s2_vld_r) begin
      if (s2_op_r == pcbh_pkg::OP_START) begin
        last_bucket_r <= '0;
      end else if ((s2_op_r == pcbh_pkg::OP_PART) && !s2_dead_r) begin
        last_bucket_r <= req.addr;
      end
    end
  end

  // block new requests from start acceptance until its sweep is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept && (op_in == pcbh_pkg::OP_START)) begin
      pend_r <= 1'b1;
    end else if (stat.clr_done) begin
      pend_r <= 1'b0;
    end
  end

  pcbh_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (req),
    .res   (res),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cell_r <= res.cell_index;
      out_inr_r  <= res.in_range;
      out_cnt_r  <= res.count;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.cell_index = out_cell_r;
  assign out_ch.in_range   = out_inr_r;
  assign out_ch.count      = out_cnt_r;

endmodule
